/* sv/utf8d_pkg.sv */
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types and constants for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

    // Width of the internal saturating character counter
    localparam int COUNT_WIDTH   = 24;
    // Widths of the result fields
    localparam int CP_WIDTH      = 21;
    localparam int TOTAL_WIDTH   = 24;
    // Stream data widths
    localparam int IN_DATA_W     = 8;
    localparam int OUT_DATA_W    = 48;
    localparam int OUT_USER_W    = 2;

    // Sequence length codes (zero means no sequence open)
    localparam logic [2:0] SEQ_NONE  = 3'd0;
    localparam logic [2:0] SEQ_TWO   = 3'd2;
    localparam logic [2:0] SEQ_THREE = 3'd3;
    localparam logic [2:0] SEQ_FOUR  = 3'd4;

    // Code point limits
    localparam logic [CP_WIDTH-1:0] FLOOR_TWO   = 21'h00007F;
    localparam logic [CP_WIDTH-1:0] FLOOR_THREE = 21'h0007FF;
    localparam logic [CP_WIDTH-1:0] FLOOR_FOUR  = 21'h00FFFF;
    localparam logic [CP_WIDTH-1:0] CP_MAX      = 21'h10FFFF;

    // One decoded result item
    typedef struct packed {
        logic [CP_WIDTH-1:0]    code_point;
        logic                   char_valid;
        logic                   string_end;
        logic                   string_error;
        logic [TOTAL_WIDTH-1:0] char_total;
    } t_result;

    // Decoder status seen by the top level
    typedef struct packed {
        logic seq_open;
        logic err;
    } t_core_status;

endpackage

/* sv/utf8_stream_decoder.sv */
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Decodes a UTF-8 byte stream into code points, one byte per clock unless the output stalls.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_axis_*: one string byte per item, tlast on the final
//   byte of each string. Output channel m_axis_*: one result item per
//   finished sequence (a bad lead byte counts as one), and one for any final byte that finishes none.
//   A byte is registered in the input register on acceptance, decoded, and
//   written into the output register, from which its result is visible.
//   Bytes in the middle of a sequence, and bytes after a sticky error, give
//   no result unless they are the final byte of the string.
//   Throughput is one byte per clock while the output is not stalled; the
//   decode stage is a single pass of shift-and-or logic and range compares
//   between the input and result registers.
//   Reset (synchronous, active low) empties both registers and returns the
//   decoder to the start of a string.
//   When the receiver holds m_axis_tready low with a result waiting, the
//   input register still fills, and a byte that gives no result still
//   advances; a byte that gives a result waits in the input register, and
//   s_axis_tready stays low until the output frees.
// ----------------------------------------------------------------------------
module utf8_stream_decoder
    import utf8d_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input bytes
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic                  s_axis_tlast,   // final_byte
    // decoded results
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [20:0] code_point, [44:21] char_total
    output logic [OUT_USER_W-1:0] m_axis_tuser,   // [0] char_valid, [1] string_error
    output logic                  m_axis_tlast    // string_end
);

    logic         r_in_valid;
    logic [7:0]   r_in_byte;
    logic         r_in_last;
    logic         r_out_valid;
    t_result      r_out;

    logic         core_emit;
    t_result      core_res;
    t_core_status core_status;
    logic         advance;
    logic         out_free;

    utf8d_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_emit   (core_emit),
        .o_res    (core_res),
        .o_status (core_status)
    );

    // Stage control
    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && (out_free || !core_emit);
    assign s_axis_tready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && core_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && core_emit) begin
            r_out <= core_res;
        end
    end

    // Output packing
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W-TOTAL_WIDTH-CP_WIDTH){1'b0}},
                            r_out.char_total, r_out.code_point};
    assign m_axis_tuser  = {r_out.string_error, r_out.char_valid};
    assign m_axis_tlast  = r_out.string_end;

`ifndef SYNTH
    // a decoded character never carries the error flag and lies in the code space
    a_valid_no_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tuser[1] &&
            (m_axis_tdata[CP_WIDTH-1:0] <= CP_MAX))
        else $error("valid character with error or out of range");

    // the count is only reported at the end of a string
    a_total_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |->
            (m_axis_tdata[CP_WIDTH+TOTAL_WIDTH-1:CP_WIDTH] == '0))
        else $error("char_total set before end of string");

    // after the final byte the decoder starts clean
    a_clear_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_last |=> !core_status.seq_open && !core_status.err)
        else $error("decoder state not cleared at end of string");

    // a byte that gives a result only advances into a free output
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && core_emit |-> out_free)
        else $error("result register overwritten");
`endif

endmodule

/* sv/utf8d_core.sv */
// ----------------------------------------------------------------------------
// utf8d_core
// Decoder state and next-state logic: one byte is consumed per step.
// ----------------------------------------------------------------------------
module utf8d_core
    import utf8d_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_byte,
    input  logic                 i_last,
    output logic                 o_emit,
    output t_result              o_res,
    output t_core_status         o_status
);

    logic [2:0]             r_seq,   n_seq;
    logic [1:0]             r_gath,  n_gath;
    logic [CP_WIDTH-1:0]    r_acc,   n_acc;
    logic                   r_good,  n_good;
    logic                   r_err,   n_err;
    logic [COUNT_WIDTH-1:0] r_count, n_count;

    logic                   do_emit;
    logic                   do_cut;
    logic                   em_valid;
    logic [CP_WIDTH-1:0]    em_cp;
    logic [CP_WIDTH-1:0]    acc_next;
    logic [1:0]             gath_next;
    logic                   good_next;
    logic                   seq_done;
    logic [CP_WIDTH-1:0]    cp_floor;
    logic [COUNT_WIDTH-1:0] count_inc;

    // Continuation datapath
    assign acc_next  = {r_acc[CP_WIDTH-7:0], i_byte[5:0]};
    assign gath_next = r_gath + 2'd1;
    assign good_next = r_good && (i_byte[7:6] == 2'b10);
    assign seq_done  = ({1'b0, gath_next} == r_seq) ||
                       ((r_seq == SEQ_FOUR) && (gath_next == 2'd0));
    assign count_inc = (r_count == '1) ? r_count : r_count + 1'b1;

    always_comb begin
        unique case (r_seq)
            SEQ_TWO:   cp_floor = FLOOR_TWO;
            SEQ_THREE: cp_floor = FLOOR_THREE;
            default:   cp_floor = FLOOR_FOUR;
        endcase
    end

    // Next state and result
    always_comb begin
        n_seq    = r_seq;
        n_gath   = r_gath;
        n_acc    = r_acc;
        n_good   = r_good;
        n_err    = r_err;
        n_count  = r_count;
        do_emit  = 1'b0;
        do_cut   = 1'b0;
        em_valid = 1'b0;
        em_cp    = '0;
        o_res    = '0;

        if (r_err) begin
            // sticky error: only the final byte reports
            do_cut = i_last;
        end else if (r_seq == SEQ_NONE) begin
            if (!i_byte[7]) begin
                do_emit  = 1'b1;
                em_valid = 1'b1;
                em_cp    = {{(CP_WIDTH-8){1'b0}}, i_byte};
            end else if (i_byte[7:5] == 3'b110) begin
                n_seq  = SEQ_TWO;
                n_acc  = {{(CP_WIDTH-5){1'b0}}, i_byte[4:0]};
                n_gath = 2'd1;
                n_good = 1'b1;
                do_cut = i_last;
            end else if (i_byte[7:4] == 4'b1110) begin
                n_seq  = SEQ_THREE;
                n_acc  = {{(CP_WIDTH-4){1'b0}}, i_byte[3:0]};
                n_gath = 2'd1;
                n_good = 1'b1;
                do_cut = i_last;
            end else if (i_byte[7:3] == 5'b11110) begin
                n_seq  = SEQ_FOUR;
                n_acc  = {{(CP_WIDTH-3){1'b0}}, i_byte[2:0]};
                n_gath = 2'd1;
                n_good = 1'b1;
                do_cut = i_last;
            end else begin
                // stray continuation or bad lead byte
                do_emit = 1'b1;
            end
        end else if (seq_done) begin
            em_cp    = acc_next;
            em_valid = good_next && (acc_next > cp_floor) && (acc_next <= CP_MAX);
            do_emit  = 1'b1;
            n_seq    = SEQ_NONE;
            n_gath   = 2'd0;
            n_acc    = '0;
            n_good   = 1'b1;
        end else begin
            n_acc  = acc_next;
            n_gath = gath_next;
            n_good = good_next;
            do_cut = i_last;
        end

        // Finish: build the result item
        if (do_cut) begin
            o_res.string_end   = 1'b1;
            o_res.string_error = 1'b1;
        end else if (do_emit) begin
            n_count            = em_valid ? count_inc : r_count;
            n_err              = !em_valid && !i_last;
            o_res.code_point   = em_valid ? em_cp : '0;
            o_res.char_valid   = em_valid;
            o_res.string_end   = i_last;
            o_res.string_error = !em_valid && !i_last;
            o_res.char_total   = i_last ? TOTAL_WIDTH'(n_count) : '0;
        end

        // End of string returns to the idle state
        if ((do_cut || do_emit) && i_last) begin
            n_seq   = SEQ_NONE;
            n_gath  = 2'd0;
            n_acc   = '0;
            n_good  = 1'b1;
            n_err   = 1'b0;
            n_count = '0;
        end
    end

    assign o_emit            = do_emit || do_cut;
    assign o_status.seq_open = (r_seq != SEQ_NONE);
    assign o_status.err      = r_err;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq   <= SEQ_NONE;
            r_gath  <= 2'd0;
            r_acc   <= '0;
            r_good  <= 1'b1;
            r_err   <= 1'b0;
            r_count <= '0;
        end else if (i_step) begin
            r_seq   <= n_seq;
            r_gath  <= n_gath;
            r_acc   <= n_acc;
            r_good  <= n_good;
            r_err   <= n_err;
            r_count <= n_count;
        end
    end

endmodule

/* bench/utf8_stream_decoder_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder_tb
// Self-checking bench for the UTF-8 stream decoder. Directed strings cover
// the byte extremes, every sequence length and the error cases. Random
// strings follow, mostly well-formed with an occasional defect, plus raw
// noise. Both stream sides stall at random. A scoreboard decodes every
// accepted byte itself and checks each result item field by field.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_tb;
    import utf8d_pkg::*;

    localparam int TARGET_BYTES = 2000;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_AT      = 200;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 10;

    // ------------------------------------------------------------------------
    // Scoreboard: own decoder state, queue of expected result items
    // ------------------------------------------------------------------------
    class char_scoreboard;
        logic [2:0]             seq_len;
        logic [1:0]             gathered;
        logic [CP_WIDTH-1:0]    acc;
        logic                   cont_ok;
        logic                   sticky_err;
        logic [COUNT_WIDTH-1:0] char_count;
        t_result                expected_chars[$];
        int                     mismatches;

        function new();
            mismatches = 0;
            clear_string();
        endfunction

        function void clear_string();
            seq_len    = SEQ_NONE;
            gathered   = '0;
            acc        = '0;
            cont_ok    = 1'b1;
            sticky_err = 1'b0;
            char_count = '0;
        endfunction

        // Finished sequence (or one-byte char / bad lead)
        function void finish_char(logic fin, logic valid, logic [CP_WIDTH-1:0] cp);
            t_result r;
            if (valid) begin
                if (char_count != '1)
                    char_count = char_count + 1'b1;
            end else if (!fin) begin
                sticky_err = 1'b1;
            end
            r.code_point   = valid ? cp : '0;
            r.char_valid   = valid;
            r.string_end   = fin;
            r.string_error = sticky_err;
            r.char_total   = (fin && !sticky_err) ? TOTAL_WIDTH'(char_count) : '0;
            expected_chars.push_back(r);
            if (fin)
                clear_string();
        endfunction

        // String ends with an error pending or a sequence still open
        function void end_in_error();
            t_result r;
            r.code_point   = '0;
            r.char_valid   = 1'b0;
            r.string_end   = 1'b1;
            r.string_error = 1'b1;
            r.char_total   = '0;
            expected_chars.push_back(r);
            clear_string();
        endfunction

        function void accept_byte(logic [7:0] b, logic fin);
            logic [CP_WIDTH-1:0] floor_cp;
            logic [CP_WIDTH-1:0] cp;
            logic                valid;
            logic                done;
            if (sticky_err) begin
                if (fin)
                    end_in_error();
                return;
            end

            // lead byte
            if (seq_len == SEQ_NONE) begin
                casez (b)
                    8'b0???????: begin
                        finish_char(fin, 1'b1, CP_WIDTH'(b));
                        return;
                    end
                    8'b110?????: begin
                        seq_len = SEQ_TWO;
                        acc     = CP_WIDTH'(b[4:0]);
                    end
                    8'b1110????: begin
                        seq_len = SEQ_THREE;
                        acc     = CP_WIDTH'(b[3:0]);
                    end
                    8'b11110???: begin
                        seq_len = SEQ_FOUR;
                        acc     = CP_WIDTH'(b[2:0]);
                    end
                    default: begin
                        finish_char(fin, 1'b0, '0);
                        return;
                    end
                endcase
                gathered = 2'd1;
                cont_ok  = 1'b1;
                if (fin)
                    end_in_error();
                return;
            end

            // continuation byte, consumed whatever it holds
            if (b[7:6] != 2'b10)
                cont_ok = 1'b0;
            acc      = {acc[CP_WIDTH-7:0], b[5:0]};
            gathered = gathered + 2'd1;
            done     = (seq_len == {1'b0, gathered}) ||
                       (seq_len == SEQ_FOUR && gathered == 2'd0);
            if (done) begin
                case (seq_len)
                    SEQ_TWO:   floor_cp = FLOOR_TWO;
                    SEQ_THREE: floor_cp = FLOOR_THREE;
                    default:   floor_cp = FLOOR_FOUR;
                endcase
                cp       = acc;
                valid    = cont_ok && cp > floor_cp && cp <= CP_MAX;
                seq_len  = SEQ_NONE;
                gathered = '0;
                acc      = '0;
                cont_ok  = 1'b1;
                finish_char(fin, valid, cp);
            end else if (fin) begin
                end_in_error();
            end
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] tdata,
                                   logic [OUT_USER_W-1:0] tuser, logic tlast);
            t_result got;
            t_result exp_r;
            got.code_point   = tdata[CP_WIDTH-1:0];
            got.char_total   = tdata[CP_WIDTH +: TOTAL_WIDTH];
            got.char_valid   = tuser[0];
            got.string_error = tuser[1];
            got.string_end   = tlast;
            if (expected_chars.size() == 0) begin
                $error("unexpected result item: tdata=%h tuser=%b tlast=%b",
                       tdata, tuser, tlast);
                mismatches++;
                return;
            end
            exp_r = expected_chars.pop_front();
            if (got.code_point !== exp_r.code_point) begin
                $error("code_point: expected %h, got %h", exp_r.code_point, got.code_point);
                mismatches++;
            end
            if (got.char_valid !== exp_r.char_valid) begin
                $error("char_valid: expected %b, got %b", exp_r.char_valid, got.char_valid);
                mismatches++;
            end
            if (got.string_end !== exp_r.string_end) begin
                $error("string_end: expected %b, got %b", exp_r.string_end, got.string_end);
                mismatches++;
            end
            if (got.string_error !== exp_r.string_error) begin
                $error("string_error: expected %b, got %b",
                       exp_r.string_error, got.string_error);
                mismatches++;
            end
            if (got.char_total !== exp_r.char_total) begin
                $error("char_total: expected %0d, got %0d", exp_r.char_total, got.char_total);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------------
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;   // [7:0] data_byte
    logic                  s_axis_tlast  = 1'b0; // final_byte
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;         // [20:0] code_point, [44:21] char_total
    logic [OUT_USER_W-1:0] m_axis_tuser;         // [0] char_valid, [1] string_error
    logic                  m_axis_tlast;         // string_end

    char_scoreboard sb = new();
    int             cycle_count = 0;
    int             bytes_sent  = 0;
    logic           tx_burst    = 1'b0;
    logic [7:0]     str[$];

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    utf8_stream_decoder u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        if ($urandom_range(0, 31) == 0)
            tx_burst = ~tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fin;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.accept_byte(b, fin);
        bytes_sent++;
    endtask

    task automatic send_string();
        for (int i = 0; i < str.size(); i++)
            send_byte(str[i], i == str.size() - 1);
    endtask

    function automatic logic [7:0] rand_cont();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    // Well-formed character of random length and value
    task automatic add_char();
        logic [CP_WIDTH-1:0] cp;
        case ($urandom_range(1, 4))
            1: str.push_back(8'($urandom_range(0, 8'h7F)));
            2: begin
                cp = CP_WIDTH'($urandom_range(21'h80, 21'h7FF));
                str.push_back({3'b110, cp[10:6]});
                str.push_back({2'b10, cp[5:0]});
            end
            3: begin
                cp = CP_WIDTH'($urandom_range(21'h800, 21'hFFFF));
                str.push_back({4'b1110, cp[15:12]});
                str.push_back({2'b10, cp[11:6]});
                str.push_back({2'b10, cp[5:0]});
            end
            default: begin
                cp = CP_WIDTH'($urandom_range(21'h10000, 21'h10FFFF));
                str.push_back({5'b11110, cp[20:18]});
                str.push_back({2'b10, cp[17:12]});
                str.push_back({2'b10, cp[11:6]});
                str.push_back({2'b10, cp[5:0]});
            end
        endcase
    endtask

    // One malformed sequence; a truncated one must close the string
    task automatic add_defect(output logic ends_string);
        int n;
        int bad_pos;
        logic [7:0] bad;
        ends_string = 1'b0;
        case ($urandom_range(0, 5))
            0: str.push_back(8'($urandom_range(8'h80, 8'hBF)));    // stray continuation
            1: str.push_back(8'($urandom_range(8'hF8, 8'hFF)));    // bad lead
            2: begin                                               // overlong
                case ($urandom_range(0, 2))
                    0: begin
                        str.push_back(8'($urandom_range(8'hC0, 8'hC1)));
                        str.push_back(rand_cont());
                    end
                    1: begin
                        str.push_back(8'hE0);
                        str.push_back(8'($urandom_range(8'h80, 8'h9F)));
                        str.push_back(rand_cont());
                    end
                    default: begin
                        str.push_back(8'hF0);
                        str.push_back(8'($urandom_range(8'h80, 8'h8F)));
                        str.push_back(rand_cont());
                        str.push_back(rand_cont());
                    end
                endcase
            end
            3: begin                                               // above the code space
                if ($urandom_range(0, 1) == 0) begin
                    str.push_back(8'hF4);
                    str.push_back(8'($urandom_range(8'h90, 8'hBF)));
                end else begin
                    str.push_back(8'($urandom_range(8'hF5, 8'hF7)));
                    str.push_back(rand_cont());
                end
                str.push_back(rand_cont());
                str.push_back(rand_cont());
            end
            4: begin                                               // bad continuation
                n       = $urandom_range(2, 4);
                bad_pos = $urandom_range(1, n - 1);
                case (n)
                    2:       str.push_back(8'($urandom_range(8'hC2, 8'hDF)));
                    3:       str.push_back(8'($urandom_range(8'hE0, 8'hEF)));
                    default: str.push_back(8'($urandom_range(8'hF0, 8'hF4)));
                endcase
                for (int i = 1; i < n; i++) begin
                    if (i == bad_pos) begin
                        bad = 8'($urandom_range(0, 8'hBF));
                        if (bad[7:6] == 2'b10)
                            bad = bad ^ 8'h40;
                        if ($urandom_range(0, 1) == 0)
                            bad = bad | 8'hC0;
                        str.push_back(bad);
                    end else begin
                        str.push_back(rand_cont());
                    end
                end
            end
            default: begin                                         // cut short by the end
                n = $urandom_range(2, 4);
                case (n)
                    2:       str.push_back(8'($urandom_range(8'hC2, 8'hDF)));
                    3:       str.push_back(8'($urandom_range(8'hE0, 8'hEF)));
                    default: str.push_back(8'($urandom_range(8'hF0, 8'hF4)));
                endcase
                repeat ($urandom_range(0, n - 2)) str.push_back(rand_cont());
                ends_string = 1'b1;
            end
        endcase
    endtask

    task automatic build_random_string();
        int   n_chars;
        int   defect_at;
        logic closed;
        str.delete();
        if ($urandom_range(0, 99) < 80) begin
            n_chars   = $urandom_range(1, 10);
            defect_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n_chars - 1) : -1;
            closed    = 1'b0;
            for (int i = 0; i < n_chars && !closed; i++) begin
                if (i == defect_at)
                    add_defect(closed);
                else
                    add_char();
            end
        end else begin
            // raw noise
            repeat ($urandom_range(1, 8)) str.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver side, with one long hold-off to back the block up
    // ------------------------------------------------------------------------
    initial begin : rx_side
        int   stall;
        int   rx_count;
        logic rx_burst;
        rx_count = 0;
        rx_burst = 1'b0;
        forever begin
            if ($urandom_range(0, 31) == 0)
                rx_burst = ~rx_burst;
            stall = rx_burst ? 0 : $urandom_range(0, 6);
            if (rx_count == HOLD_AT)
                stall = HOLD_CYCLES;
            if (stall > 0) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
            rx_count++;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main_seq
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ASCII extremes
        str = '{8'h00, 8'h7F};
        send_string();
        // smallest 2-byte, largest 3-byte, largest 4-byte
        str = '{8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBF, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_string();
        // overlong form on the final byte: reported, no sticky error
        str = '{8'hC0, 8'h80};
        send_string();
        // bad lead mid-string, rest ignored until the end
        str = '{8'hF8, 8'h41, 8'h80};
        send_string();
        // bad continuation ending on the final byte
        str = '{8'hE2, 8'h41, 8'h82};
        send_string();
        // sequence cut short by the end of the string
        str = '{8'hE2, 8'h82};
        send_string();
        // surrogate is accepted
        str = '{8'hED, 8'hA0, 8'h80};
        send_string();
        // above the code space
        str = '{8'hF4, 8'h90, 8'h80, 8'h80};
        send_string();

        while (bytes_sent < TARGET_BYTES) begin
            build_random_string();
            send_string();
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
